>>> src/rrts_pkg.sv
// Shared types and codes for the round-robin thread scheduler.
// Depends on nothing; every other file refers to it by scoped names.
package rrts_pkg;

    localparam int unsigned OP_W   = 3;
    localparam int unsigned TGT_W  = 7;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned KEY_W  = 9;
    localparam int unsigned ST_W   = 3;

    // Request codes
    localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
    localparam logic [OP_W-1:0] OP_EXIT     = 3'd1;
    localparam logic [OP_W-1:0] OP_JOIN     = 3'd2;
    localparam logic [OP_W-1:0] OP_SLEEP    = 3'd3;
    localparam logic [OP_W-1:0] OP_WAIT_KEY = 3'd4;
    localparam logic [OP_W-1:0] OP_POLL     = 3'd5;

    // Slot status codes
    localparam logic [ST_W-1:0] ST_UNUSED  = 3'd0;
    localparam logic [ST_W-1:0] ST_RUNNING = 3'd1;
    localparam logic [ST_W-1:0] ST_INPUT   = 3'd2;
    localparam logic [ST_W-1:0] ST_SLEEP   = 3'd3;
    localparam logic [ST_W-1:0] ST_JOIN    = 3'd4;
    localparam logic [ST_W-1:0] ST_EXITED  = 3'd5;
    localparam logic [ST_W-1:0] ST_READY   = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TGT_W-1:0]  target;
        logic [TIME_W-1:0] duration_ms;
        logic [TIME_W-1:0] now_ms;
        logic              key_valid;
        logic [KEY_W-1:0]  key_code;
    } t_req;

    typedef struct packed {
        logic [TGT_W-1:0] running_thread;
        logic             running_valid;
        logic [TGT_W-1:0] new_handle;
        logic [KEY_W-1:0] delivered_key;
        logic             key_delivered;
        logic             table_full;
    } t_rsp;

    // Write enables toward the slot table
    typedef struct packed {
        logic st_en;
        logic wk_en;
        logic jt_en;
    } t_mem_wr;

    // Outcome of evaluating one slot at the end of the search pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic run;
        logic got_key;
    } t_verdict;

endpackage

>>> src/rrts_slot_mem.sv
// Slot table: status, wake time and join target memories, with registered reads.
// Status has a second read port for the join target lookup. Uses rrts_pkg.
module rrts_slot_mem #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned IW    = 7
) (
    input  logic                           i_clk,
    input  rrts_pkg::t_mem_wr              i_wr,
    input  logic [IW-1:0]                  i_wr_addr,
    input  logic [rrts_pkg::ST_W-1:0]      i_wr_st,
    input  logic [rrts_pkg::TIME_W-1:0]    i_wr_wk,
    input  logic [rrts_pkg::TGT_W-1:0]     i_wr_jt,
    input  logic [IW-1:0]                  i_rd_addr,
    input  logic [IW-1:0]                  i_tg_addr,
    output logic [rrts_pkg::ST_W-1:0]      o_st_q,
    output logic [rrts_pkg::TIME_W-1:0]    o_wk_q,
    output logic [rrts_pkg::TGT_W-1:0]     o_jt_q,
    output logic [rrts_pkg::ST_W-1:0]      o_tg_st_q
);

    logic [rrts_pkg::ST_W-1:0]   r_st_mem [DEPTH];
    logic [rrts_pkg::TIME_W-1:0] r_wk_mem [DEPTH];
    logic [rrts_pkg::TGT_W-1:0]  r_jt_mem [DEPTH];

    logic [rrts_pkg::ST_W-1:0]   r_st_q;
    logic [rrts_pkg::ST_W-1:0]   r_tg_st_q;
    logic [rrts_pkg::TIME_W-1:0] r_wk_q;
    logic [rrts_pkg::TGT_W-1:0]  r_jt_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.st_en) begin
            r_st_mem[i_wr_addr] <= i_wr_st;
        end
        r_st_q    <= r_st_mem[i_rd_addr];
        r_tg_st_q <= r_st_mem[i_tg_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wk_en) begin
            r_wk_mem[i_wr_addr] <= i_wr_wk;
        end
        r_wk_q <= r_wk_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.jt_en) begin
            r_jt_mem[i_wr_addr] <= i_wr_jt;
        end
        r_jt_q <= r_jt_mem[i_rd_addr];
    end

    assign o_st_q    = r_st_q;
    assign o_tg_st_q = r_tg_st_q;
    assign o_wk_q    = r_wk_q;
    assign o_jt_q    = r_jt_q;

endmodule

>>> src/rrts_eval.sv
// Runnable test for one slot per cycle: stage 1 looks at the slot's entry and
// fetches its join target's status, stage 2 decides. Uses rrts_pkg.
module rrts_eval #(
    parameter int unsigned IW = 7,
    parameter int unsigned CW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_flush,
    input  logic                          i_s1_valid,
    input  logic                          i_s1_last,
    input  logic [IW-1:0]                 i_s1_idx,
    input  logic [rrts_pkg::ST_W-1:0]     i_st_q,
    input  logic [rrts_pkg::TIME_W-1:0]   i_wk_q,
    input  logic [rrts_pkg::TGT_W-1:0]    i_jt_q,
    input  logic [rrts_pkg::ST_W-1:0]     i_tg_st_q,
    input  logic [CW-1:0]                 i_count,
    input  logic                          i_slot0_written,
    input  logic [rrts_pkg::TIME_W-1:0]   i_now,
    input  logic                          i_key_valid,
    output logic [IW-1:0]                 o_tg_addr,
    output rrts_pkg::t_verdict            o_verdict,
    output logic [IW-1:0]                 o_idx
);

    localparam int unsigned XW = (CW > rrts_pkg::TGT_W) ? CW : rrts_pkg::TGT_W;

    logic [rrts_pkg::ST_W-1:0] st_eff;
    logic [XW-1:0]             tgt_x;
    logic                      tgt_ok;
    logic                      run;

    logic                      r_s2_valid;
    logic                      r_s2_last;
    logic [IW-1:0]             r_s2_idx;
    logic [rrts_pkg::ST_W-1:0] r_s2_st;
    logic                      r_s2_sleep_ok;
    logic                      r_s2_tgt_ok;

    // Slot 0 reads as running until its entry is first written
    assign st_eff = (i_s1_idx == '0 && !i_slot0_written) ? rrts_pkg::ST_RUNNING : i_st_q;

    // A target at or beyond the fill count was never created and cannot have exited
    assign tgt_x     = XW'(i_jt_q);
    assign o_tg_addr = tgt_x[IW-1:0];
    assign tgt_ok    = (tgt_x < XW'(i_count)) && !(tgt_x == '0 && !i_slot0_written);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_s1_valid && !i_flush;
        end
        r_s2_last     <= i_s1_last;
        r_s2_idx      <= i_s1_idx;
        r_s2_st       <= st_eff;
        r_s2_sleep_ok <= i_now >= i_wk_q;
        r_s2_tgt_ok   <= tgt_ok;
    end

    always_comb begin
        unique case (r_s2_st)
            rrts_pkg::ST_READY: run = 1'b1;
            rrts_pkg::ST_SLEEP: run = r_s2_sleep_ok;
            rrts_pkg::ST_JOIN:  run = r_s2_tgt_ok && (i_tg_st_q == rrts_pkg::ST_EXITED);
            rrts_pkg::ST_INPUT: run = i_key_valid;
            default:            run = 1'b0;
        endcase
    end

    assign o_verdict.valid   = r_s2_valid;
    assign o_verdict.last    = r_s2_last;
    assign o_verdict.run     = run;
    assign o_verdict.got_key = run && (r_s2_st == rrts_pkg::ST_INPUT);
    assign o_idx             = r_s2_idx;

endmodule

>>> src/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler: request handling, search
// sequencer and result register. Uses rrts_pkg, rrts_slot_mem and rrts_eval.
//
//  channel   direction  handshake          payload
//  request   in         i_valid / o_ready  i_req (rrts_pkg::t_req)
//  response  out        o_valid / i_ready  o_rsp (rrts_pkg::t_rsp)
//
// Create and poll skip the search: from accept the block goes to S_FIN, loads
// the result register once it is free and returns to idle. Exit, join, sleep,
// wait and any item while no thread runs search the table, one slot read per
// cycle through a 3-deep read/evaluate pipeline, stopping early when a slot
// is found. Reset is synchronous; the table needs no clearing pass (slot 0
// has one written flag, other slots are covered by the fill count). A stalled
// response holds the block after the result is computed; one item at a time.
module round_robin_thread_scheduler #(
    parameter int unsigned MAX_SLOTS = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rrts_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output rrts_pkg::t_rsp o_rsp
);

    localparam int unsigned IW = $clog2(MAX_SLOTS);
    localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
    localparam int unsigned XW = (CW > rrts_pkg::TGT_W) ? CW : rrts_pkg::TGT_W;
    localparam int unsigned TIME_W_L = rrts_pkg::TIME_W + 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FIN    = 2'd2;

    logic [1:0]          r_state, n_state;
    rrts_pkg::t_req      r_req;
    logic [IW-1:0]       r_cur;
    logic [CW-1:0]       r_count, n_count;
    logic                r_pending;
    logic                r_slot0_wr;
    logic                r_full;
    logic [rrts_pkg::TGT_W-1:0] r_handle;
    logic                r_got_key;
    logic [IW-1:0]       r_iss_idx;
    logic [CW-1:0]       r_iss_left;
    logic                r_s1_valid;
    logic                r_s1_last;
    logic [IW-1:0]       r_s1_idx;
    logic                r_out_valid;
    rrts_pkg::t_rsp      r_out;

    logic                acc;
    logic                create_ok;
    logic                create_full;
    logic                act;
    logic                do_search;
    logic [CW-1:0]       cur_inc;
    logic [IW-1:0]       start_idx;
    logic [CW-1:0]       iss_inc;
    logic                issue;
    logic                stop;
    logic                found;
    logic                out_load;
    logic [TIME_W_L-1:0] wake_sum;
    logic [XW-1:0]       cur_x;
    logic [XW-1:0]       handle_x;

    rrts_pkg::t_mem_wr             mem_wr;
    logic [IW-1:0]                 wr_addr;
    logic [rrts_pkg::ST_W-1:0]     wr_st;
    logic [rrts_pkg::TIME_W-1:0]   wr_wk;
    logic [rrts_pkg::ST_W-1:0]     st_q;
    logic [rrts_pkg::TIME_W-1:0]   wk_q;
    logic [rrts_pkg::TGT_W-1:0]    jt_q;
    logic [rrts_pkg::ST_W-1:0]     tg_st_q;
    logic [IW-1:0]                 tg_addr;
    rrts_pkg::t_verdict            verdict;
    logic [IW-1:0]                 v_idx;

    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;

    assign create_full = (i_req.op == rrts_pkg::OP_CREATE) && (r_count == CW'(MAX_SLOTS));
    assign create_ok   = (i_req.op == rrts_pkg::OP_CREATE) && !create_full;
    assign act         = !r_pending && ((i_req.op == rrts_pkg::OP_EXIT)
                                     || (i_req.op == rrts_pkg::OP_JOIN)
                                     || (i_req.op == rrts_pkg::OP_SLEEP)
                                     || (i_req.op == rrts_pkg::OP_WAIT_KEY));
    assign do_search   = r_pending || act;
    assign n_count     = r_count + CW'(create_ok);

    // Search starts after the current slot and wraps at the (updated) fill count
    assign cur_inc   = CW'(r_cur) + CW'(1);
    assign start_idx = (cur_inc == n_count) ? '0 : cur_inc[IW-1:0];
    assign iss_inc   = CW'(r_iss_idx) + CW'(1);

    assign wake_sum = TIME_W_L'(i_req.now_ms) + TIME_W_L'(i_req.duration_ms);

    assign stop  = (r_state == S_SEARCH) && verdict.valid && (verdict.run || verdict.last);
    assign found = stop && verdict.run;
    assign issue = (r_state == S_SEARCH) && (r_iss_left != '0) && !stop;

    // Table writes: request effect at accept, or the chosen slot at the end of a search
    always_comb begin
        mem_wr  = '0;
        wr_addr = r_cur;
        wr_st   = rrts_pkg::ST_RUNNING;
        wr_wk   = wake_sum[TIME_W_L-1] ? '1 : wake_sum[rrts_pkg::TIME_W-1:0];
        if (found) begin
            mem_wr.st_en = 1'b1;
            wr_addr      = v_idx;
        end else if (acc && create_ok) begin
            mem_wr.st_en = 1'b1;
            wr_addr      = r_count[IW-1:0];
            wr_st        = rrts_pkg::ST_READY;
        end else if (acc && act) begin
            mem_wr.st_en = 1'b1;
            unique case (i_req.op)
                rrts_pkg::OP_EXIT: begin
                    wr_st = rrts_pkg::ST_EXITED;
                end
                rrts_pkg::OP_JOIN: begin
                    wr_st        = rrts_pkg::ST_JOIN;
                    mem_wr.jt_en = 1'b1;
                end
                rrts_pkg::OP_SLEEP: begin
                    wr_st        = rrts_pkg::ST_SLEEP;
                    mem_wr.wk_en = 1'b1;
                end
                default: begin
                    wr_st = rrts_pkg::ST_INPUT;
                end
            endcase
        end
    end

    rrts_slot_mem #(
        .DEPTH(MAX_SLOTS),
        .IW   (IW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr     (mem_wr),
        .i_wr_addr(wr_addr),
        .i_wr_st  (wr_st),
        .i_wr_wk  (wr_wk),
        .i_wr_jt  (i_req.target),
        .i_rd_addr(r_iss_idx),
        .i_tg_addr(tg_addr),
        .o_st_q   (st_q),
        .o_wk_q   (wk_q),
        .o_jt_q   (jt_q),
        .o_tg_st_q(tg_st_q)
    );

    rrts_eval #(
        .IW(IW),
        .CW(CW)
    ) u_eval (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_flush        (stop),
        .i_s1_valid     (r_s1_valid),
        .i_s1_last      (r_s1_last),
        .i_s1_idx       (r_s1_idx),
        .i_st_q         (st_q),
        .i_wk_q         (wk_q),
        .i_jt_q         (jt_q),
        .i_tg_st_q      (tg_st_q),
        .i_count        (r_count),
        .i_slot0_written(r_slot0_wr),
        .i_now          (r_req.now_ms),
        .i_key_valid    (r_req.key_valid),
        .o_tg_addr      (tg_addr),
        .o_verdict      (verdict),
        .o_idx          (v_idx)
    );

    assign out_load = (r_state == S_FIN) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = do_search ? S_SEARCH : S_FIN;
                end
            end
            S_SEARCH: begin
                if (stop) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_count     <= CW'(1);
            r_pending   <= 1'b0;
            r_slot0_wr  <= 1'b0;
            r_iss_left  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_wr.st_en && wr_addr == '0) begin
                r_slot0_wr <= 1'b1;
            end
            if (acc) begin
                r_count    <= n_count;
                r_iss_left <= do_search ? n_count : '0;
            end else if (stop) begin
                r_iss_left <= '0;
            end else if (issue) begin
                r_iss_left <= r_iss_left - CW'(1);
            end
            r_s1_valid <= issue;
            if (stop) begin
                r_pending <= !verdict.run;
                if (verdict.run) begin
                    r_cur <= v_idx;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign cur_x    = XW'(r_cur);
    assign handle_x = XW'(r_count);

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req     <= i_req;
            r_full    <= create_full;
            r_handle  <= create_ok ? handle_x[rrts_pkg::TGT_W-1:0] : '0;
            r_got_key <= 1'b0;
            r_iss_idx <= start_idx;
        end else begin
            if (issue) begin
                r_iss_idx <= (iss_inc == r_count) ? '0 : iss_inc[IW-1:0];
            end
            if (stop) begin
                r_got_key <= verdict.got_key;
            end
        end
        r_s1_last <= (r_iss_left == CW'(1));
        r_s1_idx  <= r_iss_idx;
        if (out_load) begin
            r_out.running_thread <= r_pending ? '0 : cur_x[rrts_pkg::TGT_W-1:0];
            r_out.running_valid  <= !r_pending;
            r_out.new_handle     <= r_handle;
            r_out.delivered_key  <= r_got_key ? r_req.key_code : '0;
            r_out.key_delivered  <= r_got_key;
            r_out.table_full     <= r_full;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

>>> src/rrts_checker.sv
// Port-level checks for the round-robin thread scheduler, bound to the top level.
// Uses rrts_pkg for the payload types.
module rrts_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_ready,
    input rrts_pkg::t_rsp o_rsp
);

    // No running thread: the slot field reads zero
    a_idle_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.running_valid |-> o_rsp.running_thread == '0)
        else $error("running_thread nonzero without a running thread");

    // A key goes only to a thread that was just selected
    a_key_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.key_delivered |-> o_rsp.running_valid)
        else $error("key delivered with no running thread");

    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.key_delivered |-> o_rsp.delivered_key == '0)
        else $error("delivered_key nonzero without delivery");

    // A failed create hands out no slot
    a_full_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.table_full |-> o_rsp.new_handle == '0)
        else $error("new_handle set on a full table");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("response changed while stalled");

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (.*);

>>> verif/tb.sv
// Self-checking testbench for round_robin_thread_scheduler: directed and random
// requests, with results checked against a behavioral copy of the slot table.
// Depends on rrts_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned SLOTS = 128;
    localparam logic [rrts_pkg::OP_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [rrts_pkg::OP_W-1:0] OP_UNDEF_HI = 3'd7;

    logic i_clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    rrts_pkg::t_req req = '0;
    logic o_ready;
    logic o_valid;
    rrts_pkg::t_rsp o_rsp;

    // Behavioral slot table
    logic [rrts_pkg::ST_W-1:0]   thr_status [SLOTS];
    logic [rrts_pkg::TIME_W-1:0] thr_wake   [SLOTS];
    logic [rrts_pkg::TGT_W-1:0]  thr_join   [SLOTS];
    int                          cur_thr;
    int                          n_used;
    bit                          no_runner;

    rrts_pkg::t_rsp              sched_q [$];
    int                          mismatches = 0;
    int                          snd_idle   = 0;
    int                          rcv_idle   = 0;
    logic [rrts_pkg::TIME_W-1:0] clock_ms   = '0;

    round_robin_thread_scheduler #(.MAX_SLOTS(SLOTS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .o_ready (o_ready),
        .i_req   (req),
        .o_valid (o_valid),
        .i_ready (rsp_ready),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("round_robin_thread_scheduler: mismatch");
        $finish;
    end

    always @(negedge i_clk) begin
        rsp_ready <= ($urandom_range(99) >= rcv_idle);
    end

    function automatic bit slot_can_run(int s, logic [rrts_pkg::TIME_W-1:0] now, logic kv);
        case (thr_status[s])
            rrts_pkg::ST_READY: return 1'b1;
            rrts_pkg::ST_SLEEP: return now >= thr_wake[s];
            rrts_pkg::ST_JOIN:  return thr_status[thr_join[s]] == rrts_pkg::ST_EXITED;
            rrts_pkg::ST_INPUT: return kv;
            default:            return 1'b0;
        endcase
    endfunction

    // One round-robin pass starting after the current slot; returns 1 when an
    // input waiter was picked.
    function automatic bit pick_next_thread(logic [rrts_pkg::TIME_W-1:0] now, logic kv);
        int idx;
        bit got;
        idx = (cur_thr + 1) % n_used;
        for (int i = 0; i < n_used; i++) begin
            if (slot_can_run(idx, now, kv)) begin
                got = (thr_status[idx] == rrts_pkg::ST_INPUT);
                thr_status[idx] = rrts_pkg::ST_RUNNING;
                cur_thr = idx;
                no_runner = 1'b0;
                return got;
            end
            idx = (idx + 1) % n_used;
        end
        no_runner = 1'b1;
        return 1'b0;
    endfunction

    function automatic rrts_pkg::t_rsp schedule_step(rrts_pkg::t_req r);
        rrts_pkg::t_rsp p;
        logic [rrts_pkg::TIME_W:0] wsum;
        bit searching;
        bit got;
        p = '0;
        searching = no_runner;
        got = 1'b0;
        if (r.op == rrts_pkg::OP_CREATE) begin
            if (n_used < SLOTS) begin
                p.new_handle = 7'(n_used);
                thr_status[n_used] = rrts_pkg::ST_READY;
                n_used++;
            end else begin
                p.table_full = 1'b1;
            end
        end else if (!no_runner && (r.op == rrts_pkg::OP_EXIT || r.op == rrts_pkg::OP_JOIN ||
                                    r.op == rrts_pkg::OP_SLEEP ||
                                    r.op == rrts_pkg::OP_WAIT_KEY)) begin
            case (r.op)
                rrts_pkg::OP_EXIT: thr_status[cur_thr] = rrts_pkg::ST_EXITED;
                rrts_pkg::OP_JOIN: begin
                    thr_status[cur_thr] = rrts_pkg::ST_JOIN;
                    thr_join[cur_thr] = r.target;
                end
                rrts_pkg::OP_SLEEP: begin
                    wsum = {1'b0, r.now_ms} + {1'b0, r.duration_ms};
                    thr_wake[cur_thr] = wsum[rrts_pkg::TIME_W] ? '1
                                                               : wsum[rrts_pkg::TIME_W-1:0];
                    thr_status[cur_thr] = rrts_pkg::ST_SLEEP;
                end
                default: thr_status[cur_thr] = rrts_pkg::ST_INPUT;
            endcase
            searching = 1'b1;
        end
        if (searching)
            got = pick_next_thread(r.now_ms, r.key_valid);
        p.running_valid  = !no_runner;
        p.running_thread = no_runner ? '0 : 7'(cur_thr);
        p.key_delivered  = got;
        p.delivered_key  = got ? r.key_code : '0;
        return p;
    endfunction

    function automatic rrts_pkg::t_req make_req(logic [rrts_pkg::OP_W-1:0] op,
                                                logic [rrts_pkg::TGT_W-1:0] tgt,
                                                logic [rrts_pkg::TIME_W-1:0] dur,
                                                logic [rrts_pkg::TIME_W-1:0] now,
                                                logic kv,
                                                logic [rrts_pkg::KEY_W-1:0] code);
        rrts_pkg::t_req r;
        r.op = op;
        r.target = tgt;
        r.duration_ms = dur;
        r.now_ms = now;
        r.key_valid = kv;
        r.key_code = code;
        return r;
    endfunction

    // Pick a request that keeps threads alive: exits are rare, joins lean on
    // slots that already exited, and a stalled table gets keys and time.
    function automatic rrts_pkg::t_req random_req();
        rrts_pkg::t_req r;
        int pick;
        int exited [$];
        pick = $urandom_range(99);
        if (no_runner) begin
            if (pick < 70)      r.op = rrts_pkg::OP_POLL;
            else if (pick < 80) r.op = rrts_pkg::OP_CREATE;
            else if (pick < 95) r.op = 3'($urandom_range(rrts_pkg::OP_WAIT_KEY,
                                                         rrts_pkg::OP_EXIT));
            else                r.op = $urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO;
            r.key_valid = 1'($urandom_range(1));
        end else begin
            if (pick < 12)      r.op = rrts_pkg::OP_CREATE;
            else if (pick < 15) r.op = rrts_pkg::OP_EXIT;
            else if (pick < 23) r.op = rrts_pkg::OP_JOIN;
            else if (pick < 48) r.op = rrts_pkg::OP_SLEEP;
            else if (pick < 68) r.op = rrts_pkg::OP_WAIT_KEY;
            else if (pick < 93) r.op = rrts_pkg::OP_POLL;
            else                r.op = $urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO;
            r.key_valid = ($urandom_range(3) == 0);
        end
        for (int s = 0; s < n_used; s++)
            if (thr_status[s] == rrts_pkg::ST_EXITED) exited.push_back(s);
        pick = $urandom_range(99);
        if (pick < 60 && exited.size() != 0)
            r.target = 7'(exited[$urandom_range(exited.size() - 1)]);
        else if (pick < 85)
            r.target = 7'($urandom_range(n_used - 1));
        else
            r.target = 7'($urandom_range(SLOTS - 1));
        clock_ms += $urandom_range(40);
        r.now_ms = ($urandom_range(9) == 0) ? $urandom : clock_ms;
        r.duration_ms = ($urandom_range(9) == 0) ? $urandom : $urandom_range(300);
        r.key_code = 9'($urandom_range(511));
        return r;
    endfunction

    // Hold valid and payload until the transaction is taken; valid is left
    // high so a back-to-back item needs no extra assignment.
    task automatic send_req(input rrts_pkg::t_req r);
        while ($urandom_range(99) < snd_idle) begin
            @(negedge i_clk);
            req_valid <= 1'b0;
        end
        @(negedge i_clk);
        req_valid <= 1'b1;
        req <= r;
        do @(posedge i_clk); while (!o_ready);
        sched_q.push_back(schedule_step(r));
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        req_valid <= 1'b0;
        while (sched_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        rrts_pkg::t_rsp want;
        if (rst_n && o_valid && rsp_ready) begin
            if (sched_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual %h",
                         $time, o_rsp);
                mismatches++;
            end else begin
                want = sched_q.pop_front();
                check_field("running_thread", want.running_thread, o_rsp.running_thread);
                check_field("running_valid",  want.running_valid,  o_rsp.running_valid);
                check_field("new_handle",     want.new_handle,     o_rsp.new_handle);
                check_field("delivered_key",  want.delivered_key,  o_rsp.delivered_key);
                check_field("key_delivered",  want.key_delivered,  o_rsp.key_delivered);
                check_field("table_full",     want.table_full,     o_rsp.table_full);
            end
        end
    end

    task automatic test_directed();
        send_req(make_req(rrts_pkg::OP_POLL,     0, 0, 0, 0, 0));
        send_req(make_req(rrts_pkg::OP_CREATE,   0, 0, 0, 0, 0));
        send_req(make_req(rrts_pkg::OP_CREATE,   0, 0, 0, 0, 0));
        send_req(make_req(rrts_pkg::OP_CREATE,   0, 0, 0, 0, 0));
        send_req(make_req(rrts_pkg::OP_WAIT_KEY, 0, 0, 0, 0, 0));
        // saturating wake time
        send_req(make_req(rrts_pkg::OP_SLEEP,    0, 32'hFFFF_FFFF, 100, 0, 0));
        send_req(make_req(rrts_pkg::OP_JOIN,     1, 0, 100, 0, 0));
        send_req(make_req(rrts_pkg::OP_EXIT,     0, 0, 100, 1, 9'h1FF));
        // nothing runnable, then an exit that must be dropped
        send_req(make_req(rrts_pkg::OP_WAIT_KEY, 0, 0, 0, 0, 0));
        send_req(make_req(rrts_pkg::OP_EXIT,     0, 0, 0, 0, 0));
        send_req(make_req(rrts_pkg::OP_POLL,     0, 0, 32'hFFFF_FFFF, 0, 0));
        send_req(make_req(rrts_pkg::OP_EXIT,     0, 0, 32'hFFFF_FFFF, 0, 0));
        // join a slot never created
        send_req(make_req(rrts_pkg::OP_JOIN,     7'h7F, 0, 0, 1, 0));
        send_req(make_req(rrts_pkg::OP_CREATE,   0, 0, 0, 0, 0));
        // unknown codes act as poll; the offered key is dropped
        send_req(make_req(OP_UNDEF_LO, 0, 0, 0, 1, 9'h155));
        send_req(make_req(OP_UNDEF_HI, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 9'h0AA));
        send_req(make_req(rrts_pkg::OP_SLEEP,    0, 0, 5, 0, 0));
        send_req(make_req(rrts_pkg::OP_JOIN,     4, 0, 5, 0, 0));
        send_req(make_req(rrts_pkg::OP_SLEEP,    0, 32'h20, 32'hFFFF_FFF0, 0, 0));
        send_req(make_req(rrts_pkg::OP_CREATE,   0, 0, 0, 0, 0));
        send_req(make_req(rrts_pkg::OP_WAIT_KEY, 0, 0, 0, 1, 9'h0AA));
        send_req(make_req(rrts_pkg::OP_SLEEP,    0, 1, 10, 0, 0));
        send_req(make_req(rrts_pkg::OP_POLL,     0, 0, 11, 0, 0));
    endtask

    // Requests that the block drops while no thread runs are not counted.
    task automatic test_random(input int n, input int s_idle, input int r_idle);
        int done;
        rrts_pkg::t_req r;
        bit dropped;
        snd_idle = s_idle;
        rcv_idle = r_idle;
        done = 0;
        while (done < n) begin
            r = random_req();
            dropped = no_runner && (r.op == rrts_pkg::OP_EXIT || r.op == rrts_pkg::OP_JOIN ||
                                    r.op == rrts_pkg::OP_SLEEP ||
                                    r.op == rrts_pkg::OP_WAIT_KEY);
            send_req(r);
            if (!dropped) done++;
        end
    endtask

    task automatic test_drained_restart();
        for (int i = 0; i < 12; i++) send_req(random_req());
        wait_all_results();
        for (int i = 0; i < 12; i++) send_req(random_req());
    endtask

    task automatic test_table_full();
        while (n_used < SLOTS) send_req(make_req(rrts_pkg::OP_CREATE, 0, 0, clock_ms, 0, 0));
        send_req(make_req(rrts_pkg::OP_CREATE, 0, 0, clock_ms, 1, 9'h1FF));
        send_req(make_req(rrts_pkg::OP_CREATE, 0, 0, clock_ms, 0, 0));
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            thr_status[s] = rrts_pkg::ST_UNUSED;
            thr_wake[s] = '0;
            thr_join[s] = '0;
        end
        thr_status[0] = rrts_pkg::ST_RUNNING;
        cur_thr = 0;
        n_used = 1;
        no_runner = 1'b0;
        snd_idle = 14;
        rcv_idle = 85;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(540, 14, 85);
        test_drained_restart();
        test_random(530, 85, 14);
        wait_all_results();
        test_random(530, 0, 0);
        test_table_full();

        wait_all_results();
        repeat (SLOTS + 16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("round_robin_thread_scheduler: match");
        end else begin
            $display("round_robin_thread_scheduler: mismatch");
        end
        $finish;
    end

endmodule
